>>> hdl/mma_pkg.sv
`timescale 1ns / 1ps

package mma_pkg;

  // input word operation codes
  typedef enum logic [1:0] {
    FN_WR_A = 2'd0,
    FN_WR_B = 2'd1,
    FN_WR_C = 2'd2,
    FN_RUN  = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [2:0] CFG_A_ROWS      = 3'd0;
  localparam logic [2:0] CFG_A_COLS      = 3'd1;
  localparam logic [2:0] CFG_B_COLS      = 3'd2;
  localparam logic [2:0] CFG_INNER_START = 3'd3;
  localparam logic [2:0] CFG_B_LAYOUT    = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int ACC_W      = 32;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic c_rd;
    logic load;
    logic cap;
    logic shift;
    logic layout;
  } cell_ctl_t;

endpackage

>>> hdl/mma_if.sv
`timescale 1ns / 1ps

interface mma_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [15:0] operand_value;
  logic signed [31:0] acc_value;

  modport source (output valid, func, row, col, operand_value, acc_value, input ready);
  modport sink (input valid, func, row, col, operand_value, acc_value, output ready);
endinterface

interface mma_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [31:0] result_value;
  logic               last;

  modport source (output valid, out_row, out_col, result_value, last, input ready);
  modport sink (input valid, out_row, out_col, result_value, last, output ready);
endinterface

>>> hdl/mma_cell.sv
`timescale 1ns / 1ps

module mma_cell #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mma_pkg::cell_ctl_t           ctl,
  input  logic                         live,
  input  logic                         wr_c,
  input  logic                         wr_br,
  input  logic                         wr_bt,
  input  logic [$clog2(MAX_DIM)-1:0]   wr_row,
  input  logic [$clog2(MAX_DIM)-1:0]   wr_col,
  input  logic signed [31:0]           wr_cval,
  input  logic signed [ELEM_BITS-1:0]  wr_bval,
  input  logic [$clog2(MAX_DIM)-1:0]   rd_row,
  input  logic                         tk_in_v,
  input  logic signed [ELEM_BITS-1:0]  tk_in_a,
  input  logic [$clog2(MAX_DIM)-1:0]   tk_in_kk,
  output logic                         tk_out_v,
  output logic signed [ELEM_BITS-1:0]  tk_out_a,
  output logic [$clog2(MAX_DIM)-1:0]   tk_out_kk,
  input  logic signed [31:0]           res_in,
  output logic signed [31:0]           res_out
);
  import mma_pkg::*;

  localparam int RW = $clog2(MAX_DIM);
  localparam int PW = 2 * ELEM_BITS;
  localparam int SW = ((PW > ACC_W) ? PW : ACC_W) + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(32'sh7fffffff);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(32'sh7fffffff) - SW'(1);

  // local column of C, B by row (row-major load) and B by column (transposed load)
  logic signed [ELEM_BITS-1:0] mem_br [MAX_DIM];
  logic signed [ELEM_BITS-1:0] mem_bt [MAX_DIM];
  logic signed [31:0]          mem_c  [MAX_DIM];

  logic signed [ELEM_BITS-1:0] br_rd_r, bt_rd_r;
  logic signed [31:0]          c_rd_r;
  logic                        v_r, pv_r;
  logic signed [ELEM_BITS-1:0] a_r;
  logic [RW-1:0]               kk_r;
  logic signed [PW-1:0]        prod_r;
  logic signed [31:0]          acc_r, res_r;

  logic signed [ELEM_BITS-1:0] b_sel;
  logic signed [SW-1:0]        sum;
  logic signed [31:0]          sum_sat;
  logic                        c_we;
  logic [RW-1:0]               c_addr;
  logic signed [31:0]          c_wdata;

  // b operand memories, read at the arriving token's index and registered alongside it
  always_ff @(posedge clk) begin
    if (wr_br) mem_br[wr_row] <= wr_bval;
    if (wr_bt) mem_bt[wr_col] <= wr_bval;
    br_rd_r <= mem_br[tk_in_kk];
    bt_rd_r <= mem_bt[tk_in_kk];
  end

  // c column: loaded from the input or written back at row end
  assign c_we    = wr_c | (ctl.cap & live);
  assign c_addr  = ctl.cap ? rd_row : wr_row;
  assign c_wdata = ctl.cap ? acc_r : wr_cval;

  always_ff @(posedge clk) begin
    if (c_we) mem_c[c_addr] <= c_wdata;
    if (ctl.c_rd) c_rd_r <= mem_c[rd_row];
  end

  // token stage handed to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      v_r  <= tk_in_v;
      pv_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= tk_in_a;
    kk_r <= tk_in_kk;
  end

  assign tk_out_v  = v_r;
  assign tk_out_a  = a_r;
  assign tk_out_kk = kk_r;

  // product stage
  assign b_sel = ctl.layout ? bt_rd_r : br_rd_r;

  always_ff @(posedge clk) begin
    prod_r <= PW'(a_r) * PW'(b_sel);
  end

  // saturating accumulate
  always_comb begin
    sum = SW'(acc_r) + SW'(prod_r);
    if (sum > SAT_HI)      sum_sat = 32'sh7fffffff;
    else if (sum < SAT_LO) sum_sat = 32'sh80000000;
    else                   sum_sat = 32'(sum);
  end

  always_ff @(posedge clk) begin
    if (ctl.load)   acc_r <= c_rd_r;
    else if (pv_r)  acc_r <= sum_sat;
  end

  // result shift line toward cell zero
  always_ff @(posedge clk) begin
    if (ctl.cap)        res_r <= acc_r;
    else if (ctl.shift) res_r <= res_in;
  end

  assign res_out = res_r;

endmodule

>>> hdl/matrix_multiply_accumulate.sv
`timescale 1ns / 1ps

// Matrix multiply-accumulate engine, Q8.8 operands, Q16.16 saturating accumulator.
// in_s carries words: write A, write B, write C (one element each) or run.
// Write words leave in_ready high and produce nothing on out_m.
// A run word computes C[i][j] += sum A[i][k]*B[k-inner_start][j] and sends the
// updated C elements row-major on out_m, last set on the final one.
// A row of MAX_DIM cells, one per C column, holds the B and C columns; A elements
// stream through the row, one cell further each cycle.
// Per C row: C is read and loaded (ST_RDC, ST_LDC), (a_cols - inner_start) A words
// are streamed, the cell row drains (ST_DRAIN), ST_CAP captures the results, then
// b_cols words go out (one per cycle with out ready). A run holds in_ready low
// until its last word is taken; out_m holds its word while the receiver stalls.
// Write the size and layout registers (cfg_we/cfg_index/cfg_data) only while idle;
// the block does not enforce it. rst_n (synchronous) resets the sequencer, sizes
// to 8 and inner_start/layout to 0; store contents stay undefined until written.

module matrix_multiply_accumulate #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data,
  mma_in_if.sink                           in_s,
  mma_out_if.source                        out_m
);
  import mma_pkg::*;

  localparam int RW  = $clog2(MAX_DIM);
  localparam int XW  = (RW > 3) ? RW : 3;
  localparam int CW  = (RW + 1 > 4) ? RW + 1 : 4;
  localparam int AW  = 2 * RW;
  localparam int XE  = (ELEM_BITS > 16) ? ELEM_BITS : 16;
  localparam int DRAIN_CYC = MAX_DIM + 4;
  localparam int DW  = $clog2(DRAIN_CYC + 1);
  localparam logic [6:0]    MD7 = 7'(MAX_DIM);
  localparam logic [CW-1:0] MDC = CW'(MAX_DIM);
  localparam logic [AW-1:0] MDA = AW'(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDC, ST_LDC, ST_STREAM, ST_DRAIN, ST_CAP, ST_EMIT
  } state_t;

  state_t            state_r;
  logic [3:0]        a_rows_r, a_cols_r, b_cols_r;
  logic [2:0]        inner_start_r;
  logic              b_layout_r;
  logic [CW-1:0]     i_r, j_r, k_r;
  logic [DW-1:0]     drain_r;
  logic              head_v_r;
  logic [RW-1:0]     head_kk_r;
  logic signed [ELEM_BITS-1:0] a_rd_r;
  logic signed [ELEM_BITS-1:0] amem [MAX_DIM * MAX_DIM];

  logic [CW-1:0]     nr, nk, nc, s_ext;
  logic              in_acc, out_acc, in_range;
  logic [RW-1:0]     w_row, w_col;
  logic [AW-1:0]     a_waddr, a_raddr;
  logic signed [ELEM_BITS-1:0] elem;
  logic [XE-1:0]     elem_x;
  cell_ctl_t         ctl;

  logic                        tv [MAX_DIM+1];
  logic signed [ELEM_BITS-1:0] ta [MAX_DIM+1];
  logic [RW-1:0]               tk [MAX_DIM+1];
  logic signed [31:0]          rs [MAX_DIM+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r      <= 4'd8;
      a_cols_r      <= 4'd8;
      b_cols_r      <= 4'd8;
      inner_start_r <= 3'd0;
      b_layout_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_A_ROWS:      a_rows_r      <= cfg_data;
        CFG_A_COLS:      a_cols_r      <= cfg_data;
        CFG_B_COLS:      b_cols_r      <= cfg_data;
        CFG_INNER_START: inner_start_r <= cfg_data[2:0];
        CFG_B_LAYOUT:    b_layout_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sizes clamped to the store
  assign nr    = (CW'(a_rows_r) > MDC) ? MDC : CW'(a_rows_r);
  assign nk    = (CW'(a_cols_r) > MDC) ? MDC : CW'(a_cols_r);
  assign nc    = (CW'(b_cols_r) > MDC) ? MDC : CW'(b_cols_r);
  assign s_ext = CW'(inner_start_r);

  // input word decode
  assign in_s.ready = (state_r == ST_IDLE);
  assign in_acc     = in_s.valid & in_s.ready;
  assign in_range   = ({4'd0, in_s.row} < MD7) && ({4'd0, in_s.col} < MD7);
  assign w_row      = RW'(XW'(in_s.row));
  assign w_col      = RW'(XW'(in_s.col));
  assign elem_x     = XE'(unsigned'(in_s.operand_value));
  assign elem       = elem_x[ELEM_BITS-1:0];
  assign a_waddr    = AW'(w_row) * MDA + AW'(w_col);
  assign a_raddr    = AW'(i_r[RW-1:0]) * MDA + AW'(k_r[RW-1:0]);

  // a store, read at the streamed inner index
  always_ff @(posedge clk) begin
    if (in_acc && in_range && in_s.func == FN_WR_A) amem[a_waddr] <= elem;
    a_rd_r <= amem[a_raddr];
  end

  assign out_acc = out_m.valid & out_m.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_v_r <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      drain_r  <= '0;
    end else begin
      head_v_r  <= (state_r == ST_STREAM);
      head_kk_r <= RW'(k_r - s_ext);
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_s.func == FN_RUN && nr != '0 && nc != '0) begin
            i_r     <= '0;
            state_r <= ST_RDC;
          end
        end
        ST_RDC: state_r <= ST_LDC;
        ST_LDC: begin
          k_r     <= s_ext;
          drain_r <= '0;
          state_r <= (s_ext < nk) ? ST_STREAM : ST_DRAIN;
        end
        ST_STREAM: begin
          k_r <= k_r + CW'(1);
          if (k_r == nk - CW'(1)) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          drain_r <= drain_r + DW'(1);
          if (drain_r == DW'(DRAIN_CYC - 1)) state_r <= ST_CAP;
        end
        ST_CAP: begin
          j_r     <= '0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_acc) begin
            j_r <= j_r + CW'(1);
            if (j_r == nc - CW'(1)) begin
              if (i_r == nr - CW'(1)) begin
                state_r <= ST_IDLE;
              end else begin
                i_r     <= i_r + CW'(1);
                state_r <= ST_RDC;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // cell control broadcast
  assign ctl.c_rd   = (state_r == ST_RDC);
  assign ctl.load   = (state_r == ST_LDC);
  assign ctl.cap    = (state_r == ST_CAP);
  assign ctl.shift  = out_acc;
  assign ctl.layout = b_layout_r;

  // head of the cell row
  assign tv[0] = head_v_r;
  assign ta[0] = a_rd_r;
  assign tk[0] = head_kk_r;
  assign rs[MAX_DIM] = '0;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    logic wr_ok;
    assign wr_ok = in_acc & in_range;

    mma_cell #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .live      (CW'(g) < nc),
      .wr_c      (wr_ok && in_s.func == FN_WR_C && w_col == RW'(g)),
      .wr_br     (wr_ok && in_s.func == FN_WR_B && w_col == RW'(g)),
      .wr_bt     (wr_ok && in_s.func == FN_WR_B && w_row == RW'(g)),
      .wr_row    (w_row),
      .wr_col    (w_col),
      .wr_cval   (in_s.acc_value),
      .wr_bval   (elem),
      .rd_row    (i_r[RW-1:0]),
      .tk_in_v   (tv[g]),
      .tk_in_a   (ta[g]),
      .tk_in_kk  (tk[g]),
      .tk_out_v  (tv[g+1]),
      .tk_out_a  (ta[g+1]),
      .tk_out_kk (tk[g+1]),
      .res_in    (rs[g+1]),
      .res_out   (rs[g])
    );
  end

  // output word
  assign out_m.valid        = (state_r == ST_EMIT);
  assign out_m.out_row      = 3'(i_r);
  assign out_m.out_col      = 3'(j_r);
  assign out_m.result_value = rs[0];
  assign out_m.last         = (i_r == nr - CW'(1)) && (j_r == nc - CW'(1));

endmodule

>>> hdl/mma_chk.sv
`timescale 1ns / 1ps

module mma_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_row,
  input logic [2:0]  out_col,
  input logic [31:0] out_value,
  input logic        out_last
);
  import mma_pkg::*;

  // input is never taken while a result word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while output pending");

  // a store write word leaves the input open for the next word
  a_wr_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func != FN_RUN) |=> in_ready)
    else $error("input closed after write word");

  // the readout stops after the word marked last
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("output continues after last");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_row) && $stable(out_col) && $stable(out_value)
       && $stable(out_last)))
    else $error("stalled output word changed");

endmodule

bind matrix_multiply_accumulate mma_chk u_mma_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_func   (in_s.func),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_row   (out_m.out_row),
  .out_col   (out_m.out_col),
  .out_value (out_m.result_value),
  .out_last  (out_m.last)
);
